// ===== hw/rtl/raster_local_extrema_3x3_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the local extrema core
// Concurrent checks on the rising clock edge; disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef RASTER_LOCAL_EXTREMA_3X3_CORE_ASSERT_SVH
`define RASTER_LOCAL_EXTREMA_3X3_CORE_ASSERT_SVH

// expr must hold on every edge
`define RLX3_ASSERT_HOLDS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// cons must hold on the same edge as ante
`define RLX3_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// cons must hold on the edge after ante
`define RLX3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/rlx3_pkg.sv =====
// ----------------------------------------------------------------------------
// rlx3_pkg
// Shared constants, payload types and codes of the 3x3 local extrema core.
// ----------------------------------------------------------------------------
`default_nettype none

package rlx3_pkg;

	localparam int MAX_WIDTH       = 1024;
	localparam int MAX_HEIGHT      = 65535;
	localparam int VALUE_BITS      = 32;
	localparam int STORE_ROWS      = 4;

	localparam int COL_BITS        = $clog2(MAX_WIDTH);
	// arrival row runs up to MAX_HEIGHT+1 on the frame-end tick
	localparam int ROW_BITS        = $clog2(MAX_HEIGHT + 2);
	localparam int OUT_ROW_BITS    = 16;
	localparam int STORE_ROW_BITS  = $clog2(STORE_ROWS);
	localparam int STORE_ADDR_BITS = STORE_ROW_BITS + COL_BITS;
	localparam int STORE_DEPTH     = STORE_ROWS * MAX_WIDTH;
	localparam int CELL_BITS       = VALUE_BITS + 1;

	localparam int WIDTH_REG_BITS  = 11;
	localparam int HEIGHT_REG_BITS = 16;
	localparam int CFG_DATA_BITS   = 16;
	localparam int CFG_INDEX_BITS  = 3;

	localparam int FIFO_DEPTH      = 8;
	localparam int FIFO_PTR_BITS   = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_BITS   = FIFO_PTR_BITS + 1;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_PAD    = 1'b1;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_GRID_WIDTH,
		REG_GRID_HEIGHT,
		REG_TIES_EXTREME,
		REG_ABSOLUTE_ONLY,
		REG_EDGE_ALLOWED
	} cfg_reg_t;

	typedef enum logic [1:0] {
		KIND_LOCAL_MIN,
		KIND_LOCAL_MAX,
		KIND_ABS_MIN,
		KIND_ABS_MAX
	} kind_t;

	typedef struct packed {
		logic                         nodata;
		logic signed [VALUE_BITS-1:0] value;
	} cell_t;

	typedef struct packed {
		logic                         command;
		logic signed [VALUE_BITS-1:0] cell_value;
		logic                         cell_is_nodata;
	} grid_item_t;

	typedef struct packed {
		kind_t                        kind;
		logic [COL_BITS-1:0]          column;
		logic [OUT_ROW_BITS-1:0]      row;
		logic signed [VALUE_BITS-1:0] value;
		logic                         last;
	} report_t;

	// up to two reports enter the queue per cycle
	typedef struct packed {
		logic [1:0] count;
		report_t    item0;
		report_t    item1;
	} push_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rlx3_line_ram.sv =====
// ----------------------------------------------------------------------------
// rlx3_line_ram
// Simple dual-read RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module rlx3_line_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rlx3_result_fifo.sv =====
// ----------------------------------------------------------------------------
// rlx3_result_fifo
// Report queue: takes zero, one or two items a cycle, hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module rlx3_result_fifo (
	input  logic                               clk,
	input  logic                               arst_n,
	input  rlx3_pkg::push_t                    push,
	input  logic                               take,
	output logic                               valid,
	output rlx3_pkg::report_t                  item,
	output logic [rlx3_pkg::FIFO_CNT_BITS-1:0] count
);

	import rlx3_pkg::*;

	report_t                  store_q [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0] wr_q;
	logic [FIFO_PTR_BITS-1:0] rd_q;
	logic [FIFO_CNT_BITS-1:0] cnt_q;
	logic                     pop;
	logic [FIFO_PTR_BITS-1:0] wr_next1;

	assign valid    = (cnt_q != '0);
	assign item     = store_q[rd_q];
	assign count    = cnt_q;
	assign pop      = valid && take;
	assign wr_next1 = wr_q + FIFO_PTR_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + FIFO_PTR_BITS'(push.count);
			rd_q  <= rd_q + FIFO_PTR_BITS'(pop);
			cnt_q <= cnt_q + FIFO_CNT_BITS'(push.count) - FIFO_CNT_BITS'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			store_q[wr_q] <= push.item0;
		end
		if (push.count == 2'd2) begin
			store_q[wr_next1] <= push.item1;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/raster_local_extrema_3x3_core.sv =====
// ----------------------------------------------------------------------------
// raster_local_extrema_3x3_core
// Streams raster cells through a four-row line store and a sliding 3x3
// window; reports local minima/maxima or the frame's absolute records.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle unless grid_ready drops for lack of queue room;
//   the line store is read (two rows) and written (arriving row) on each accepted item.
// Reports: the deciding item passes the stage 1 and stage 2 registers, then the
//   report is queued; a cell is decided W+1 items after it arrives (W = grid width).
// Reset: async, clears positions, window, records and report queue.
//   The line store is not cleared and needs no clearing pass.
`default_nettype none
`include "raster_local_extrema_3x3_core_assert.svh"

module raster_local_extrema_3x3_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rlx3_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [rlx3_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                grid_valid,
	output logic                                grid_ready,
	input  rlx3_pkg::grid_item_t                grid_item,
	output logic                                report_valid,
	input  logic                                report_ready,
	output rlx3_pkg::report_t                   report_item
);

	import rlx3_pkg::*;

	typedef struct packed {
		logic [COL_BITS-1:0]          col;
		logic [OUT_ROW_BITS-1:0]      row;
		logic signed [VALUE_BITS-1:0] value;
	} record_t;

	// configuration
	logic [WIDTH_REG_BITS-1:0]  grid_width_q;
	logic [HEIGHT_REG_BITS-1:0] grid_height_q;
	logic                       ties_q;
	logic                       absolute_only_q;
	logic                       edge_allowed_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q    <= WIDTH_REG_BITS'(MAX_WIDTH);
			grid_height_q   <= HEIGHT_REG_BITS'(1);
			ties_q          <= 1'b0;
			absolute_only_q <= 1'b0;
			edge_allowed_q  <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_GRID_WIDTH:    grid_width_q    <= cfg_data[WIDTH_REG_BITS-1:0];
				REG_GRID_HEIGHT:   grid_height_q   <= cfg_data[HEIGHT_REG_BITS-1:0];
				REG_TIES_EXTREME:  ties_q          <= cfg_data[0];
				REG_ABSOLUTE_ONLY: absolute_only_q <= cfg_data[0];
				REG_EDGE_ALLOWED:  edge_allowed_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// clamped frame size
	logic [WIDTH_REG_BITS-1:0] gw_m1;
	logic [COL_BITS-1:0]       wm1;
	logic [ROW_BITS-1:0]       h_eff;

	assign gw_m1 = grid_width_q - WIDTH_REG_BITS'(1);

	always_comb begin
		if (grid_width_q == '0) begin
			wm1 = '0;
		end else if (grid_width_q > WIDTH_REG_BITS'(MAX_WIDTH)) begin
			wm1 = COL_BITS'(MAX_WIDTH - 1);
		end else begin
			wm1 = gw_m1[COL_BITS-1:0];
		end
		if (grid_height_q == '0) begin
			h_eff = ROW_BITS'(1);
		end else if (ROW_BITS'(grid_height_q) > ROW_BITS'(MAX_HEIGHT)) begin
			h_eff = ROW_BITS'(MAX_HEIGHT);
		end else begin
			h_eff = ROW_BITS'(grid_height_q);
		end
	end

	// ---------------- stage 0: arrival, store write, row reads ----------------
	logic [COL_BITS-1:0]       acol_q;
	logic [ROW_BITS-1:0]       arow_q;
	logic                      grid_fire;
	cell_t                     wcell;
	logic                      c_nz;
	logic                      have;
	logic [ROW_BITS-1:0]       dr;
	logic [COL_BITS-1:0]       dc;
	logic                      decide;
	logic                      frame_end;
	logic [STORE_ROW_BITS-1:0] row_mid;
	logic [STORE_ROW_BITS-1:0] row_top;

	assign grid_fire = grid_valid && grid_ready;
	assign c_nz      = (acol_q != '0);
	assign have      = c_nz ? (arow_q >= ROW_BITS'(1)) : (arow_q >= ROW_BITS'(2));
	assign dr        = c_nz ? (arow_q - ROW_BITS'(1)) : (arow_q - ROW_BITS'(2));
	assign dc        = c_nz ? (acol_q - COL_BITS'(1)) : wm1;
	assign decide    = have && (dr < h_eff) && (dc <= wm1);
	assign frame_end = (arow_q >= (h_eff + ROW_BITS'(1)));
	assign row_mid   = arow_q[STORE_ROW_BITS-1:0] - STORE_ROW_BITS'(1);
	assign row_top   = arow_q[STORE_ROW_BITS-1:0] - STORE_ROW_BITS'(2);

	always_comb begin
		if (grid_item.command == CMD_PAD) begin
			wcell.nodata = 1'b1;
			wcell.value  = '0;
		end else begin
			wcell.nodata = grid_item.cell_is_nodata;
			wcell.value  = grid_item.cell_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acol_q <= '0;
			arow_q <= '0;
		end else if (grid_fire) begin
			if (frame_end) begin
				acol_q <= '0;
				arow_q <= '0;
			end else if (acol_q >= wm1) begin
				acol_q <= '0;
				arow_q <= arow_q + ROW_BITS'(1);
			end else begin
				acol_q <= acol_q + COL_BITS'(1);
			end
		end
	end

	cell_t rd_mid;
	cell_t rd_top;

	rlx3_line_ram #(
		.WIDTH (CELL_BITS),
		.DEPTH (STORE_DEPTH)
	) u_line_ram (
		.clk     (clk),
		.we      (grid_fire),
		.waddr   ({arow_q[STORE_ROW_BITS-1:0], acol_q}),
		.wdata   (wcell),
		.raddr_a ({row_mid, acol_q}),
		.rdata_a (rd_mid),
		.raddr_b ({row_top, acol_q}),
		.rdata_b (rd_top)
	);

	// ---------------- stage 1: window shift and neighbour compare ----------------
	logic                    v_s1;
	logic                    dec_s1;
	logic                    fe_s1;
	logic                    top_ok_s1;
	logic                    bot_ok_s1;
	logic                    left_ok_s1;
	logic                    right_ok_s1;
	logic [OUT_ROW_BITS-1:0] dr_s1;
	logic [COL_BITS-1:0]     dc_s1;
	cell_t                   fwd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= grid_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (grid_fire) begin
			dec_s1      <= decide;
			fe_s1       <= frame_end;
			top_ok_s1   <= (dr != '0);
			bot_ok_s1   <= ((dr + ROW_BITS'(1)) < h_eff);
			left_ok_s1  <= (dc != '0);
			right_ok_s1 <= (dc < wm1);
			dr_s1       <= dr[OUT_ROW_BITS-1:0];
			dc_s1       <= dc;
			fwd_s1      <= wcell;  // bottom-right cell is the one arriving now
		end
	end

	// window columns, index 0 top, 1 middle, 2 bottom
	cell_t win_l_q [3];
	cell_t win_c_q [3];
	cell_t col_in  [3];

	assign col_in[0] = rd_top;
	assign col_in[1] = rd_mid;
	assign col_in[2] = fwd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				win_l_q[k] <= '0;
				win_c_q[k] <= '0;
			end
		end else if (v_s1) begin
			for (int k = 0; k < 3; k++) begin
				win_l_q[k] <= win_c_q[k];
				win_c_q[k] <= col_in[k];
			end
		end
	end

	cell_t                        ctr;
	logic signed [VALUE_BITS-1:0] nb_v  [8];
	logic                         nb_ok [8];
	logic                         is_min;
	logic                         is_max;
	logic                         min_s1;
	logic                         max_s1;

	assign ctr = win_c_q[1];

	always_comb begin
		nb_v[0] = win_l_q[0].value; nb_ok[0] = top_ok_s1 && left_ok_s1;
		nb_v[1] = win_c_q[0].value; nb_ok[1] = top_ok_s1;
		nb_v[2] = col_in[0].value;  nb_ok[2] = top_ok_s1 && right_ok_s1;
		nb_v[3] = win_l_q[1].value; nb_ok[3] = left_ok_s1;
		nb_v[4] = col_in[1].value;  nb_ok[4] = right_ok_s1;
		nb_v[5] = win_l_q[2].value; nb_ok[5] = bot_ok_s1 && left_ok_s1;
		nb_v[6] = win_c_q[2].value; nb_ok[6] = bot_ok_s1;
		nb_v[7] = col_in[2].value;  nb_ok[7] = bot_ok_s1 && right_ok_s1;

		is_min = 1'b1;
		is_max = 1'b1;
		for (int i = 0; i < 8; i++) begin
			if (nb_ok[i]) begin
				if (ties_q) begin
					if (nb_v[i] < ctr.value) is_min = 1'b0;
					if (ctr.value < nb_v[i]) is_max = 1'b0;
				end else begin
					if (!(ctr.value < nb_v[i])) is_min = 1'b0;
					if (!(nb_v[i] < ctr.value)) is_max = 1'b0;
				end
			end else if (!edge_allowed_q) begin
				is_min = 1'b0;
				is_max = 1'b0;
			end
		end
		min_s1 = dec_s1 && !ctr.nodata && is_min;
		max_s1 = dec_s1 && !ctr.nodata && is_max;
	end

	// ---------------- stage 2: records and report generation ----------------
	logic                         v_s2;
	logic                         min_s2;
	logic                         max_s2;
	logic                         fe_s2;
	logic [OUT_ROW_BITS-1:0]      dr_s2;
	logic [COL_BITS-1:0]          dc_s2;
	logic signed [VALUE_BITS-1:0] val_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			min_s2 <= min_s1;
			max_s2 <= max_s1;
			fe_s2  <= fe_s1;
			dr_s2  <= dr_s1;
			dc_s2  <= dc_s1;
			val_s2 <= ctr.value;
		end
	end

	record_t    min_q;
	record_t    max_q;
	logic [1:0] rec_found_q;  // bit 0 min, bit 1 max
	record_t    here;
	record_t    min_new;
	record_t    max_new;
	logic [1:0] found_new;
	logic       take_min;
	logic       take_max;
	push_t      push;

	function automatic report_t make_report(kind_t kind, record_t rec, logic last);
		report_t r;
		r.kind   = kind;
		r.column = rec.col;
		r.row    = rec.row;
		r.value  = rec.value;
		r.last   = last;
		return r;
	endfunction

	assign here.col   = dc_s2;
	assign here.row   = dr_s2;
	assign here.value = val_s2;

	// absolute mode: a record moves only on a strictly better value
	assign take_min  = absolute_only_q && min_s2 && (!rec_found_q[0] || (val_s2 < min_q.value));
	assign take_max  = absolute_only_q && !take_min && max_s2
	                   && (!rec_found_q[1] || (max_q.value < val_s2));
	assign min_new   = take_min ? here : min_q;
	assign max_new   = take_max ? here : max_q;
	assign found_new = rec_found_q | {take_max, take_min};

	always_comb begin
		push = '0;
		if (v_s2) begin
			if (!absolute_only_q) begin
				if (min_s2) begin
					push.count = 2'd1;
					push.item0 = make_report(KIND_LOCAL_MIN, here, 1'b1);
				end else if (max_s2) begin
					push.count = 2'd1;
					push.item0 = make_report(KIND_LOCAL_MAX, here, 1'b1);
				end
			end else if (fe_s2) begin
				if (found_new[0] && found_new[1]) begin
					push.count = 2'd2;
					push.item0 = make_report(KIND_ABS_MIN, min_new, 1'b0);
					push.item1 = make_report(KIND_ABS_MAX, max_new, 1'b1);
				end else if (found_new[0]) begin
					push.count = 2'd1;
					push.item0 = make_report(KIND_ABS_MIN, min_new, 1'b1);
				end else if (found_new[1]) begin
					push.count = 2'd1;
					push.item0 = make_report(KIND_ABS_MAX, max_new, 1'b1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q       <= '0;
			max_q       <= '0;
			rec_found_q <= '0;
		end else if (v_s2) begin
			if (fe_s2) begin
				min_q       <= '0;
				max_q       <= '0;
				rec_found_q <= '0;
			end else begin
				min_q       <= min_new;
				max_q       <= max_new;
				rec_found_q <= found_new;
			end
		end
	end

	// ---------------- report queue and input credit ----------------
	logic [FIFO_CNT_BITS-1:0] fifo_count;
	logic [FIFO_CNT_BITS:0]   need;

	rlx3_result_fifo u_result_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.take   (report_ready),
		.valid  (report_valid),
		.item   (report_item),
		.count  (fifo_count)
	);

	// each item in flight may still add two reports
	assign need = {1'b0, fifo_count}
	              + (FIFO_CNT_BITS + 1)'({v_s1, 1'b0})
	              + (FIFO_CNT_BITS + 1)'({v_s2, 1'b0})
	              + (FIFO_CNT_BITS + 1)'(2);
	assign grid_ready = (need <= (FIFO_CNT_BITS + 1)'(FIFO_DEPTH));

	// ---------------- assertions ----------------
	`RLX3_ASSERT_HOLDS(a_queue_room, clk, arst_n, (({1'b0, fifo_count} + (FIFO_CNT_BITS + 1)'(push.count)) <= (FIFO_CNT_BITS + 1)'(FIFO_DEPTH)), "report queue overrun")
	`RLX3_ASSERT_NEXT(a_records_cleared, clk, arst_n, v_s2 && fe_s2, rec_found_q == 2'b00, "records not cleared at frame end")
	`RLX3_ASSERT_IMPLIES(a_one_local_report, clk, arst_n, v_s2 && !absolute_only_q, push.count <= 2'd1, "more than one local report per item")
	`RLX3_ASSERT_IMPLIES(a_stall_has_cause, clk, arst_n, !grid_ready, v_s1 || v_s2 || (fifo_count != '0), "input stalled with empty pipeline")

endmodule

`default_nettype wire

// ===== verif/tb_raster_local_extrema_3x3_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_raster_local_extrema_3x3_core
// Streams whole frames through the core and checks every report against a
// cycle-free predictor of the 3x3 extrema search. The predictor keeps its own
// line store, positions and records. Config is reloaded between frames once
// the core has drained. Both handshakes see random gaps except during one
// long full-rate frame.
// ----------------------------------------------------------------------------

module tb_raster_local_extrema_3x3_core;

	import rlx3_pkg::*;

	localparam int unsigned RANDOM_ITEMS  = 920;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned END_SETTLE    = 20;
	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned SHOWN_ERRORS  = 10;

	typedef struct {
		int unsigned                  col;
		int unsigned                  row;
		logic signed [VALUE_BITS-1:0] value;
	} record_t;

	// Predicts the reports of the core and checks the ones it emits.
	class extrema_tracker;
		logic [WIDTH_REG_BITS-1:0]  width_reg  = WIDTH_REG_BITS'(MAX_WIDTH);
		logic [HEIGHT_REG_BITS-1:0] height_reg = HEIGHT_REG_BITS'(1);
		bit                         ties_ok, abs_only, edge_ok;
		cell_t                      store [STORE_DEPTH];
		int unsigned                at_col, at_row;
		record_t                    min_rec, max_rec;
		bit                         have_min, have_max;
		report_t                    pending [$];
		int unsigned                errors;

		function int unsigned eff_width();
			if (width_reg == 0)
				return 1;
			return (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
		endfunction

		function int unsigned eff_height();
			if (height_reg == 0)
				return 1;
			return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
		endfunction

		function int unsigned addr(int unsigned r, int unsigned c);
			return (r % STORE_ROWS) * MAX_WIDTH + (c % MAX_WIDTH);
		endfunction

		function report_t make_report(kind_t k, int unsigned col, int unsigned row,
				logic signed [VALUE_BITS-1:0] v);
			report_t rp;
			rp.kind   = k;
			rp.column = COL_BITS'(col);
			rp.row    = OUT_ROW_BITS'(row);
			rp.value  = v;
			rp.last   = 1'b0;
			return rp;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] data);
			case (idx)
				REG_GRID_WIDTH: begin
					width_reg = data[WIDTH_REG_BITS-1:0];
				end
				REG_GRID_HEIGHT: begin
					height_reg = data[HEIGHT_REG_BITS-1:0];
				end
				REG_TIES_EXTREME: begin
					ties_ok = data[0];
				end
				REG_ABSOLUTE_ONLY: begin
					abs_only = data[0];
				end
				REG_EDGE_ALLOWED: begin
					edge_ok = data[0];
				end
				default: begin
				end
			endcase
		endfunction

		// One accepted item: store it, decide the cell it completes, handle frame end.
		function void note_item(grid_item_t it);
			int unsigned                  w, h, c, r, dr, dc;
			int                           nr, nc, di, dj;
			bit                           take, lowest, highest;
			cell_t                        ctr, nb;
			logic signed [VALUE_BITS-1:0] cv, nv;
			report_t                      made [$];
			w = eff_width();
			h = eff_height();
			c = at_col;
			r = at_row;
			if (it.command == CMD_PAD) begin
				store[addr(r, c)] = '{nodata: 1'b1, value: '0};
			end else begin
				store[addr(r, c)] = '{nodata: it.cell_is_nodata, value: it.cell_value};
			end
			take = 1'b0;
			dr = 0;
			dc = 0;
			if (c >= 1 && r >= 1) begin
				dr = r - 1;
				dc = c - 1;
				take = 1'b1;
			end else if (c == 0 && r >= 2) begin
				dr = r - 2;
				dc = w - 1;
				take = 1'b1;
			end
			if (take && dr < h && dc < w) begin
				ctr = store[addr(dr, dc)];
				cv = ctr.value;
				if (!ctr.nodata) begin
					lowest = 1'b1;
					highest = 1'b1;
					for (di = -1; di <= 1; di++) begin
						for (dj = -1; dj <= 1; dj++) begin
							if (di == 0 && dj == 0)
								continue;
							nr = int'(dr) + di;
							nc = int'(dc) + dj;
							if (nr >= 0 && nc >= 0 && nr < int'(h) && nc < int'(w)) begin
								nb = store[addr(nr, nc)];
								nv = nb.value;
								// no-data neighbours still compare by stored value
								if (ties_ok) begin
									if (nv < cv)
										lowest = 1'b0;
									if (cv < nv)
										highest = 1'b0;
								end else begin
									if (!(cv < nv))
										lowest = 1'b0;
									if (!(nv < cv))
										highest = 1'b0;
								end
							end else if (!edge_ok) begin
								lowest = 1'b0;
								highest = 1'b0;
							end
						end
					end
					if (abs_only) begin
						if (lowest && have_min && !(cv < min_rec.value))
							lowest = 1'b0;
						if (highest && have_max && !(max_rec.value < cv))
							highest = 1'b0;
						// a tied min candidate may still take the max record
						if (lowest) begin
							min_rec = '{dc, dr, cv};
							have_min = 1'b1;
						end else if (highest) begin
							max_rec = '{dc, dr, cv};
							have_max = 1'b1;
						end
					end else if (lowest) begin
						made.push_back(make_report(KIND_LOCAL_MIN, dc, dr, cv));
					end else if (highest) begin
						made.push_back(make_report(KIND_LOCAL_MAX, dc, dr, cv));
					end
				end
			end
			if (r >= h + 1) begin
				if (abs_only) begin
					if (have_min)
						made.push_back(make_report(KIND_ABS_MIN, min_rec.col, min_rec.row,
							min_rec.value));
					if (have_max && made.size() < 2)
						made.push_back(make_report(KIND_ABS_MAX, max_rec.col, max_rec.row,
							max_rec.value));
				end
				have_min = 1'b0;
				have_max = 1'b0;
				min_rec = '{0, 0, '0};
				max_rec = '{0, 0, '0};
				at_col = 0;
				at_row = 0;
			end else if (c + 1 >= w) begin
				at_col = 0;
				at_row = r + 1;
			end else begin
				at_col = c + 1;
			end
			if (made.size() > 0)
				made[made.size() - 1].last = 1'b1;
			foreach (made[i])
				pending.push_back(made[i]);
		endfunction

		function void check(report_t got);
			report_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= SHOWN_ERRORS)
					$display("unexpected report: kind=%0d col=%0d row=%0d value=%0d last=%0b",
						got.kind, got.column, got.row, got.value, got.last);
				return;
			end
			want = pending.pop_front();
			if (got.kind !== want.kind || got.column !== want.column || got.row !== want.row
					|| got.value !== want.value || got.last !== want.last) begin
				errors++;
				if (errors <= SHOWN_ERRORS) begin
					$display("report mismatch: exp kind=%0d col=%0d row=%0d value=%0d last=%0b",
						want.kind, want.column, want.row, want.value, want.last);
					$display("                 got kind=%0d col=%0d row=%0d value=%0d last=%0b",
						got.kind, got.column, got.row, got.value, got.last);
				end
			end
		endfunction
	endclass

	logic                      clk          = 1'b0;
	logic                      arst_n       = 1'b0;
	logic                      cfg_valid    = 1'b0;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index    = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data     = '0;
	logic                      grid_valid   = 1'b0;
	logic                      grid_ready;
	grid_item_t                grid_item    = '0;
	logic                      report_valid;
	logic                      report_ready = 1'b0;
	report_t                   report_item;

	extrema_tracker tracker = new();
	bit             no_gaps = 1'b0;
	int unsigned    items_sent;
	int unsigned    cycle_count;

	raster_local_extrema_3x3_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.grid_valid   (grid_valid),
		.grid_ready   (grid_ready),
		.grid_item    (grid_item),
		.report_valid (report_valid),
		.report_ready (report_ready),
		.report_item  (report_item)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[raster_local_extrema_3x3_core] ERROR");
			$finish;
		end
	end

	always @(negedge clk) begin
		report_ready <= arst_n && (no_gaps || $urandom_range(99) >= 6);
	end

	always @(posedge clk) begin
		if (arst_n && report_valid && report_ready)
			tracker.check(report_item);
	end

	function automatic grid_item_t sample(logic signed [VALUE_BITS-1:0] v, bit nd);
		grid_item_t it;
		it.command = CMD_SAMPLE;
		it.cell_value = v;
		it.cell_is_nodata = nd;
		return it;
	endfunction

	function automatic grid_item_t pad_tick();
		grid_item_t it;
		it.command = CMD_PAD;
		it.cell_value = $urandom;
		it.cell_is_nodata = 1'($urandom_range(1));
		return it;
	endfunction

	function automatic grid_item_t random_cell(int unsigned spread);
		grid_item_t  it;
		int unsigned pick;
		pick = $urandom_range(99);
		it.command = ($urandom_range(99) < 3) ? CMD_PAD : CMD_SAMPLE;
		it.cell_is_nodata = ($urandom_range(99) < 8);
		if (pick < 6)
			it.cell_value = $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
		else if (pick < 30)
			it.cell_value = $urandom;
		else
			it.cell_value = int'($urandom_range(2 * spread)) - int'(spread);
		return it;
	endfunction

	task automatic send_item(grid_item_t it);
		@(negedge clk);
		while (!no_gaps && $urandom_range(99) < 6) begin
			grid_valid <= 1'b0;
			@(negedge clk);
		end
		grid_valid <= 1'b1;
		grid_item <= it;
		@(posedge clk);
		while (!grid_ready)
			@(posedge clk);
		tracker.note_item(it);
		items_sent++;
	endtask

	task automatic stop_items();
		@(negedge clk);
		grid_valid <= 1'b0;
	endtask

	task automatic wait_idle(int unsigned settle);
		while (tracker.pending.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic put_reg(cfg_reg_t idx, int unsigned data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data[CFG_DATA_BITS-1:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		tracker.write_reg(idx, data[CFG_DATA_BITS-1:0]);
	endtask

	task automatic load_config(int unsigned w_reg, int unsigned h_reg, bit ties, bit absol,
			bit edge_ok);
		wait_idle(SETTLE_CYCLES);
		put_reg(REG_GRID_WIDTH, w_reg);
		put_reg(REG_GRID_HEIGHT, h_reg);
		put_reg(REG_TIES_EXTREME, ties);
		put_reg(REG_ABSOLUTE_ONLY, absol);
		put_reg(REG_EDGE_ALLOWED, edge_ok);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Full frame of random cells, then width+1 trailing ticks.
	task automatic run_frame(int unsigned w_reg, int unsigned h_reg, bit ties, bit absol,
			bit edge_ok);
		int unsigned spread;
		load_config(w_reg, h_reg, ties, absol, edge_ok);
		spread = $urandom_range(1, 20);
		repeat (tracker.eff_width() * tracker.eff_height())
			send_item(random_cell(spread));
		repeat (tracker.eff_width() + 1) begin
			// samples past the grid act as trailing ticks
			if ($urandom_range(99) < 20)
				send_item(sample($urandom, 1'($urandom_range(1))));
			else
				send_item(pad_tick());
		end
		stop_items();
	endtask

	initial begin
		int unsigned w_pick, h_pick;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// 3x3, strict, edges allowed: extremes, no-data centre, tick inside frame, ties
		load_config(3, 3, 1'b0, 1'b0, 1'b1);
		send_item(sample(-5, 1'b0));
		send_item(sample(9, 1'b0));
		send_item(sample(32'sh80000000, 1'b0));
		send_item(sample(32'sh7FFFFFFF, 1'b0));
		send_item(sample(7, 1'b1));
		send_item(pad_tick());
		send_item(sample(3, 1'b0));
		send_item(sample(3, 1'b0));
		send_item(sample(-1, 1'b0));
		send_item(pad_tick());
		send_item(pad_tick());
		send_item(sample(100, 1'b0));
		send_item(pad_tick());
		stop_items();

		// flat 3x2 in tie and absolute mode: min record first, then the max record
		load_config(3, 2, 1'b1, 1'b1, 1'b1);
		repeat (6) send_item(sample(4, 1'b0));
		repeat (4) send_item(pad_tick());
		stop_items();

		while (items_sent < RANDOM_ITEMS) begin
			w_pick = $urandom_range(99);
			h_pick = $urandom_range(99);
			if (w_pick < 5)
				w_pick = 0;
			else if (w_pick < 12)
				w_pick = $urandom_range(12, 64);
			else
				w_pick = $urandom_range(1, 10);
			if (h_pick < 4)
				h_pick = 0;
			else if (h_pick < 10)
				h_pick = $urandom_range(8, 16);
			else
				h_pick = $urandom_range(1, 6);
			run_frame(w_pick, h_pick, 1'($urandom_range(1)), 1'($urandom_range(1)),
				1'($urandom_range(1)));
		end

		// long frame with no gaps on either side
		no_gaps = 1'b1;
		run_frame(48, 6, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1);
		no_gaps = 1'b0;
		run_frame(1, 3, 1'b0, 1'b1, 1'b1);

		wait_idle(END_SETTLE);
		if (tracker.errors == 0)
			$display("[raster_local_extrema_3x3_core] OK");
		else
			$display("[raster_local_extrema_3x3_core] ERROR");
		$finish;
	end

endmodule
